/* hdl/rmq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

	// Where the directly rooted component lands
	typedef enum logic [1:0] {
		SEL_X = 2'd0,
		SEL_Y = 2'd1,
		SEL_Z = 2'd2,
		SEL_W = 2'd3
	} sel_t;

	// Per-word side information carried down the cell chain
	typedef struct packed {
		sel_t       sel;
		logic       invalid;
		logic [2:0] neg;
	} meta_t;

endpackage
`default_nettype wire

/* hdl/rmq_sqrt_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One restoring square root step: consumes two radicand bits, yields one
// root bit, and hands the partial state to the next cell.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell
	import rmq_pkg::*;
#(
	parameter int W = 16
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*W-1:0] v_i,
	input  logic [W+1:0]   rem_i,
	input  logic [W-1:0]   root_i,
	output logic [2*W-1:0] v_q,
	output logic [W+1:0]   rem_q,
	output logic [W-1:0]   root_q
);

	logic [W+3:0] t;
	logic [W+3:0] trial;
	logic         ge;
	logic [W+3:0] diff;

	// trial subtract of (4*root + 1)
	assign t     = {rem_i, v_i[2*W-1 -: 2]};
	assign trial = {2'b00, root_i, 2'b01};
	assign ge    = (t >= trial);
	assign diff  = ge ? (t - trial) : t;

	always_ff @(posedge clk) begin
		if (en) begin
			v_q    <= {v_i[2*W-3:0], 2'b00};
			rem_q  <= diff[W+1:0];
			root_q <= {root_i[W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

/* hdl/rmq_div_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_div_cell
// One restoring division step: shifts in one dividend bit, yields one
// quotient bit into the low end of the shared dividend/quotient word.
// ----------------------------------------------------------------------------
module rmq_div_cell
	import rmq_pkg::*;
#(
	parameter int W = 16
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W:0]     div_i,
	input  logic [W:0]     rem_i,
	input  logic [2*W-1:0] dq_i,
	output logic [W:0]     rem_q,
	output logic [2*W-1:0] dq_q
);

	logic [W+1:0] t;
	logic         ge;
	logic [W+1:0] diff;

	assign t    = {rem_i, dq_i[2*W-1]};
	assign ge   = (t >= {1'b0, div_i});
	assign diff = ge ? (t - {1'b0, div_i}) : t;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= diff[W:0];
			dq_q  <= {dq_i[2*W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

/* hdl/rotation_matrix_to_quaternion.sv */
`default_nettype none
// Stages in order: one input stage, one
// square root cell per root bit, one setup stage, one division cell per
// quotient bit, one output register.
// Throughput: one word per cycle; a stalled output freezes the whole chain.
// Reset clears only the valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix in signed Q2.FRAC to a unit quaternion
// using a chain of square root cells followed by three division lanes.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
	import rmq_pkg::*;
#(
	parameter int DATA_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// m00 m01 m02 m10 m11 m12 m20 m21 m22, zero padded
	input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// qw qx qy qz, zero padded
	output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	// invalid
	output logic [0:0] m_tuser
);

	localparam int W      = DATA_WIDTH;
	localparam int FRAC   = W - 2;
	localparam int OUT_TW = ((4*W+7)/8)*8;

	logic en;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---------------- input decode ----------------
	logic signed [W+2:0] e [0:2][0:2];
	logic signed [W:0]   f [0:2][0:2];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				e[r][c] = {{3{s_tdata[(3*r+c)*W+W-1]}}, s_tdata[(3*r+c)*W +: W]};
				f[r][c] = {s_tdata[(3*r+c)*W+W-1], s_tdata[(3*r+c)*W +: W]};
			end
		end
	end

	logic signed [W+2:0] tr;
	logic signed [W+2:0] one;
	logic signed [W+2:0] s;
	logic signed [W:0]   n [0:2];
	sel_t                sel;
	logic                ax_gt;
	logic                pos;

	assign one = (W+3)'(1) <<< FRAC;
	assign tr  = e[0][0] + e[1][1] + e[2][2];
	assign pos = (tr > 0);

	// pick the case and form the root argument and the three numerators
	always_comb begin
		ax_gt = (e[1][1] > e[0][0]);
		if (pos) begin
			sel  = SEL_W;
			s    = tr + one;
			n[0] = f[2][1] - f[1][2];
			n[1] = f[0][2] - f[2][0];
			n[2] = f[1][0] - f[0][1];
		end else if (e[2][2] > (ax_gt ? e[1][1] : e[0][0])) begin
			sel  = SEL_Z;
			s    = e[2][2] - e[0][0] - e[1][1] + one;
			n[0] = f[1][0] - f[0][1];
			n[1] = f[0][2] + f[2][0];
			n[2] = f[1][2] + f[2][1];
		end else if (ax_gt) begin
			sel  = SEL_Y;
			s    = e[1][1] - e[2][2] - e[0][0] + one;
			n[0] = f[0][2] - f[2][0];
			n[1] = f[2][1] + f[1][2];
			n[2] = f[0][1] + f[1][0];
		end else begin
			sel  = SEL_X;
			s    = e[0][0] - e[1][1] - e[2][2] + one;
			n[0] = f[2][1] - f[1][2];
			n[1] = f[1][0] + f[0][1];
			n[2] = f[2][0] + f[0][2];
		end
	end

	// ---------------- square root chain ----------------
	logic [2*W-1:0] sqv_s   [0:W];
	logic [W+1:0]   sqrem_s [0:W];
	logic [W-1:0]   sqrt_s  [0:W];
	logic [W:0]     sqmag_s [0:W][0:2];
	meta_t          sqmeta_s[0:W];
	logic           sqval_s [0:W];

	logic invalid_c;
	assign invalid_c = (s <= 0);

	// input stage
	always_ff @(posedge clk) begin
		if (en) begin
			sqv_s[0]         <= invalid_c ? '0 : {s[W+1:0], {FRAC{1'b0}}};
			sqmeta_s[0].sel  <= sel;
			sqmeta_s[0].invalid <= invalid_c;
			sqmeta_s[0].neg  <= {n[2][W], n[1][W], n[0][W]};
			sqmag_s[0][0]    <= n[0][W] ? (-n[0]) : n[0];
			sqmag_s[0][1]    <= n[1][W] ? (-n[1]) : n[1];
			sqmag_s[0][2]    <= n[2][W] ? (-n[2]) : n[2];
		end
	end

	assign sqrem_s[0] = '0;
	assign sqrt_s[0]  = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqval_s[0] <= 1'b0;
		end else if (en) begin
			sqval_s[0] <= s_tvalid;
		end
	end

	genvar k, l;
	generate
		for (k = 0; k < W; k++) begin : g_sq
			rmq_sqrt_cell #(.W(W)) u_cell (
				.clk   (clk),
				.en    (en),
				.v_i   (sqv_s[k]),
				.rem_i (sqrem_s[k]),
				.root_i(sqrt_s[k]),
				.v_q   (sqv_s[k+1]),
				.rem_q (sqrem_s[k+1]),
				.root_q(sqrt_s[k+1])
			);

			// side data rides along with the cell
			always_ff @(posedge clk) begin
				if (en) begin
					sqmeta_s[k+1] <= sqmeta_s[k];
					for (int m = 0; m < 3; m++) begin
						sqmag_s[k+1][m] <= sqmag_s[k][m];
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sqval_s[k+1] <= 1'b0;
				end else if (en) begin
					sqval_s[k+1] <= sqval_s[k];
				end
			end
		end
	endgenerate

	// ---------------- division chain ----------------
	logic [W:0]     drem_s  [0:2][0:2*W];
	logic [2*W-1:0] ddq_s   [0:2][0:2*W];
	logic [W:0]     ddiv_s  [0:2*W];
	logic [W-1:0]   droot_s [0:2*W];
	meta_t          dmeta_s [0:2*W];
	logic           dval_s  [0:2*W];

	// setup: dividend = mag * 2^FRAC + r, divisor = 2r
	always_ff @(posedge clk) begin
		if (en) begin
			ddiv_s[0]  <= {sqrt_s[W], 1'b0};
			droot_s[0] <= sqrt_s[W];
			dmeta_s[0] <= sqmeta_s[W];
			ddq_s[0][0] <= {1'b0, sqmag_s[W][0], {FRAC{1'b0}}}
				+ {{W{1'b0}}, sqrt_s[W]};
			ddq_s[1][0] <= {1'b0, sqmag_s[W][1], {FRAC{1'b0}}}
				+ {{W{1'b0}}, sqrt_s[W]};
			ddq_s[2][0] <= {1'b0, sqmag_s[W][2], {FRAC{1'b0}}}
				+ {{W{1'b0}}, sqrt_s[W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dval_s[0] <= 1'b0;
		end else if (en) begin
			dval_s[0] <= sqval_s[W];
		end
	end

	generate
		for (l = 0; l < 3; l++) begin : g_lane
			assign drem_s[l][0] = '0;
			for (k = 0; k < 2*W; k++) begin : g_dv
				rmq_div_cell #(.W(W)) u_cell (
					.clk  (clk),
					.en   (en),
					.div_i(ddiv_s[k]),
					.rem_i(drem_s[l][k]),
					.dq_i (ddq_s[l][k]),
					.rem_q(drem_s[l][k+1]),
					.dq_q (ddq_s[l][k+1])
				);
			end
		end

		for (k = 0; k < 2*W; k++) begin : g_dside
			always_ff @(posedge clk) begin
				if (en) begin
					ddiv_s[k+1]  <= ddiv_s[k];
					droot_s[k+1] <= droot_s[k];
					dmeta_s[k+1] <= dmeta_s[k];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dval_s[k+1] <= 1'b0;
				end else if (en) begin
					dval_s[k+1] <= dval_s[k];
				end
			end
		end
	endgenerate

	// ---------------- saturate and place ----------------
	localparam logic [2*W-1:0] PMAX = (2*W)'((64'd1 << (W-1)) - 64'd1);
	localparam logic [2*W-1:0] NMAX = (2*W)'(64'd1 << (W-1));

	logic [W-1:0] lane_v [0:2];
	logic [W:0]   half_w;
	logic [W-1:0] root_v;
	logic [W-1:0] qw_c, qx_c, qy_c, qz_c;
	meta_t        fm;
	logic [2*W-1:0] qv;

	assign fm = dmeta_s[2*W];

	always_comb begin
		for (int m = 0; m < 3; m++) begin
			qv = ddq_s[m][2*W];
			if (!fm.neg[m]) begin
				lane_v[m] = (qv > PMAX) ? PMAX[W-1:0] : qv[W-1:0];
			end else begin
				lane_v[m] = (qv >= NMAX) ? NMAX[W-1:0] : (-qv[W-1:0]);
			end
		end
	end

	assign half_w = {1'b0, droot_s[2*W]} + (W+1)'(1);
	assign root_v = half_w[W] ? PMAX[W-1:0] : half_w[W:1];

	always_comb begin
		unique case (fm.sel)
			SEL_W: begin
				qw_c = root_v;    qx_c = lane_v[0]; qy_c = lane_v[1]; qz_c = lane_v[2];
			end
			SEL_X: begin
				qw_c = lane_v[0]; qx_c = root_v;    qy_c = lane_v[1]; qz_c = lane_v[2];
			end
			SEL_Y: begin
				qw_c = lane_v[0]; qx_c = lane_v[2]; qy_c = root_v;    qz_c = lane_v[1];
			end
			SEL_Z: begin
				qw_c = lane_v[0]; qx_c = lane_v[1]; qy_c = lane_v[2]; qz_c = root_v;
			end
			default: begin
				qw_c = '0; qx_c = '0; qy_c = '0; qz_c = '0;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (fm.invalid) begin
				m_tdata <= '0;
			end else begin
				m_tdata <= OUT_TW'({qz_c, qy_c, qx_c, qw_c});
			end
			m_tuser[0] <= fm.invalid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dval_s[2*W];
		end
	end

	// ---------------- checks ----------------
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("invalid word carries nonzero data");

	a_stall_holds_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(dval_s[2*W]) && $stable(sqval_s[W]) && $stable(sqval_s[0]))
		else $error("chain moved during output stall");

	a_root_lane_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		dval_s[2*W] && !fm.invalid |-> droot_s[2*W] != '0)
		else $error("zero root on a valid word");

endmodule
`default_nettype wire
